@@ sv/lae_pkg.sv @@
// shared types and constants for the linear adsr envelope block
package lae_pkg;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 3;
   localparam int SEGMENT_WIDTH = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_ATTACK_LEN = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_DECAY_LEN = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_SUSTAIN_LEVEL = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RELEASE_LEN = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_TOTAL_LEN = 3'd4;

   localparam logic [SEGMENT_WIDTH-1:0] SEG_ATTACK = 3'd0;
   localparam logic [SEGMENT_WIDTH-1:0] SEG_DECAY = 3'd1;
   localparam logic [SEGMENT_WIDTH-1:0] SEG_SUSTAIN = 3'd2;
   localparam logic [SEGMENT_WIDTH-1:0] SEG_RELEASE = 3'd3;
   localparam logic [SEGMENT_WIDTH-1:0] SEG_PAST_END = 3'd4;

   typedef struct packed {
      logic accept;
      logic classify;
      logic multiply;
      logic divide;
      logic envelope;
      logic scale;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
   } ctrl_status_type;

endpackage

@@ sv/linear_adsr_envelope_top.sv @@
// Linear ADSR envelope: each input word carries one signed sample and a restart
// flag; the block answers with one word holding the sample scaled by the envelope
// at the current position, the segment code and the envelope value. A word in a
// ramp passes through the restoring divider, which forms one quotient bit per
// cycle; in sustain or past the end the divide is skipped. A finished result sits
// in an output register, so the next word is taken while it waits. The user must
// write the registers over the csr port only while idle; the block itself does
// not enforce it.
module linear_adsr_envelope_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int LENGTH_WIDTH = 28,
   parameter int ENV_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample_in
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  req_tdata,
   // restart
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sample_out, envelope
   output logic [((SAMPLE_WIDTH+ENV_FRAC_BITS+8)/8)*8-1:0] rsp_tdata,
   // segment
   output logic [lae_pkg::SEGMENT_WIDTH-1:0]  rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lae_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lae_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lae_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import lae_pkg::*;

   localparam int QW = ENV_FRAC_BITS + 1;
   localparam int LW = LENGTH_WIDTH;
   localparam int OUT_W = ((SAMPLE_WIDTH + QW + 7) / 8) * 8;

   logic [LW-1:0] attack_len_ff, decay_len_ff, release_len_ff, total_len_ff;
   logic [QW-1:0] sustain_level_ff;
   logic [REG_INDEX_WIDTH-1:0] reg_index;
   logic csr_write;

   ctrl_cmd_type cmd;
   ctrl_status_type status;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic [SEGMENT_WIDTH-1:0] segment;
   logic [QW-1:0] envelope;

   assign csr_pready = 1'b1;
   assign reg_index = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff <= LW'(480);
         decay_len_ff <= LW'(4800);
         sustain_level_ff <= QW'(45875);
         release_len_ff <= LW'(9600);
         total_len_ff <= LW'(48000);
      end else if (csr_write) begin
         unique case (reg_index)
            REG_ATTACK_LEN: attack_len_ff <= csr_pwdata[LW-1:0];
            REG_DECAY_LEN: decay_len_ff <= csr_pwdata[LW-1:0];
            REG_SUSTAIN_LEVEL: sustain_level_ff <= csr_pwdata[QW-1:0];
            REG_RELEASE_LEN: release_len_ff <= csr_pwdata[LW-1:0];
            REG_TOTAL_LEN: total_len_ff <= csr_pwdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ATTACK_LEN: csr_prdata = CSR_DATA_WIDTH'(attack_len_ff);
         REG_DECAY_LEN: csr_prdata = CSR_DATA_WIDTH'(decay_len_ff);
         REG_SUSTAIN_LEVEL: csr_prdata = CSR_DATA_WIDTH'(sustain_level_ff);
         REG_RELEASE_LEN: csr_prdata = CSR_DATA_WIDTH'(release_len_ff);
         REG_TOTAL_LEN: csr_prdata = CSR_DATA_WIDTH'(total_len_ff);
         default: csr_prdata = '0;
      endcase
   end

   lae_ctrl #(
      .ENV_FRAC_BITS(ENV_FRAC_BITS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd(cmd),
      .status(status)
   );

   lae_datapath #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .LENGTH_WIDTH(LENGTH_WIDTH),
      .ENV_FRAC_BITS(ENV_FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .sample_in(req_tdata[SAMPLE_WIDTH-1:0]),
      .restart(req_tuser),
      .attack_len(attack_len_ff),
      .decay_len(decay_len_ff),
      .sustain_level(sustain_level_ff),
      .release_len(release_len_ff),
      .total_len(total_len_ff),
      .sample_out(sample_out),
      .segment(segment),
      .envelope(envelope)
   );

   assign rsp_tdata = OUT_W'({envelope, sample_out});
   assign rsp_tuser = segment;

endmodule

@@ sv/lae_ctrl.sv @@
// sequencer for one word: classify, multiply, serial divide when a ramp needs it, envelope, scale, output
module lae_ctrl #(
   parameter int ENV_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output lae_pkg::ctrl_cmd_type    cmd,
   input  lae_pkg::ctrl_status_type status
);
   import lae_pkg::*;

   localparam int QW = ENV_FRAC_BITS + 1;
   localparam int CW = $clog2(QW);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLASSIFY = 7'b0000010,
      ST_MULTIPLY = 7'b0000100,
      ST_DIVIDE   = 7'b0001000,
      ST_ENVELOPE = 7'b0010000,
      ST_SCALE    = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            count_in = '0;
            state_in = status.need_div ? ST_DIVIDE : ST_ENVELOPE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CW'(QW - 1)) begin
               state_in = ST_ENVELOPE;
            end
         end
         ST_ENVELOPE: begin
            cmd.envelope = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/lae_datapath.sv @@
// position counter, segment select, multiplier, restoring divider and output register
module lae_datapath #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int LENGTH_WIDTH = 28,
   parameter int ENV_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lae_pkg::ctrl_cmd_type             cmd,
   output lae_pkg::ctrl_status_type          status,
   input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
   input  logic                              restart,
   input  logic [LENGTH_WIDTH-1:0]           attack_len,
   input  logic [LENGTH_WIDTH-1:0]           decay_len,
   input  logic [ENV_FRAC_BITS:0]            sustain_level,
   input  logic [LENGTH_WIDTH-1:0]           release_len,
   input  logic [LENGTH_WIDTH-1:0]           total_len,
   output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
   output logic [lae_pkg::SEGMENT_WIDTH-1:0] segment,
   output logic [ENV_FRAC_BITS:0]            envelope
);
   import lae_pkg::*;

   localparam int QW = ENV_FRAC_BITS + 1;
   localparam int LW = LENGTH_WIDTH;
   localparam int PW = SAMPLE_WIDTH + QW + 1;
   localparam logic [QW-1:0] ENV_ONE = QW'(1) << ENV_FRAC_BITS;

   logic [LW-1:0] pos_ff, pos_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [SEGMENT_WIDTH-1:0] seg_ff, seg_in;
   logic [QW-1:0] mul_a_ff, mul_a_in;
   logic [LW-1:0] mul_b_ff, mul_b_in;
   logic [LW-1:0] div_ff, div_in;
   logic [QW-1:0] base_ff, base_in;
   logic need_div_ff, need_div_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic [QW-1:0] env_ff;
   logic signed [PW-1:0] scaled_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff;
   logic [SEGMENT_WIDTH-1:0] out_seg_ff;
   logic [QW-1:0] out_env_ff;

   logic [QW-1:0] sus;
   logic [LW:0] sus_start;
   logic rel_valid;
   logic [LW-1:0] rel_start;
   logic [LW:0] trial;
   logic fits;

   // classify the current position
   always_comb begin
      sus = (sustain_level > ENV_ONE) ? ENV_ONE : sustain_level;
      sus_start = {1'b0, attack_len} + {1'b0, decay_len};
      rel_valid = total_len > release_len;
      rel_start = total_len - release_len;
      seg_in = SEG_PAST_END;
      mul_a_in = '0;
      mul_b_in = '0;
      div_in = '0;
      base_in = '0;
      need_div_in = 1'b0;
      pos_in = pos_ff;
      if (pos_ff < total_len) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff < attack_len) begin
            seg_in = SEG_ATTACK;
            mul_a_in = ENV_ONE;
            mul_b_in = pos_ff;
            div_in = attack_len;
            need_div_in = 1'b1;
         end else if ({1'b0, pos_ff} < sus_start) begin
            seg_in = SEG_DECAY;
            mul_a_in = ENV_ONE - sus;
            mul_b_in = LW'(sus_start - {1'b0, pos_ff});
            div_in = decay_len;
            base_in = sus;
            need_div_in = 1'b1;
         end else if (!rel_valid || pos_ff < rel_start) begin
            seg_in = SEG_SUSTAIN;
            base_in = sus;
         end else begin
            seg_in = SEG_RELEASE;
            mul_a_in = sus;
            mul_b_in = total_len - pos_ff;
            div_in = release_len;
            need_div_in = 1'b1;
         end
      end
   end

   // one restoring step per cycle, quotient shifts in from the bottom
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign fits = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.multiply) begin
         {rem_in, quo_in} = mul_a_ff * mul_b_ff;
      end else if (cmd.divide) begin
         rem_in = fits ? LW'(trial - {1'b0, div_ff}) : trial[LW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         need_div_ff <= 1'b0;
      end else begin
         if (cmd.accept && restart) begin
            pos_ff <= '0;
         end else if (cmd.classify) begin
            pos_ff <= pos_in;
         end
         if (cmd.classify) begin
            need_div_ff <= need_div_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= sample_in;
      end
      if (cmd.classify) begin
         seg_ff <= seg_in;
         mul_a_ff <= mul_a_in;
         mul_b_ff <= mul_b_in;
         div_ff <= div_in;
         base_ff <= base_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.envelope) begin
         env_ff <= base_ff + quo_ff;
      end
      if (cmd.scale) begin
         scaled_ff <= PW'(sample_ff) * signed'({1'b0, env_ff});
      end
      if (cmd.load_out) begin
         out_sample_ff <= scaled_ff[ENV_FRAC_BITS +: SAMPLE_WIDTH];
         out_seg_ff <= seg_ff;
         out_env_ff <= env_ff;
      end
   end

   assign status.need_div = need_div_ff;
   assign sample_out = out_sample_ff;
   assign segment = out_seg_ff;
   assign envelope = out_env_ff;

endmodule

@@ sv/lae_checker.sv @@
// port-level checks for the linear adsr envelope block, bound to the top level
module lae_checker #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ENV_FRAC_BITS = 16
) (
   input logic                                            clock,
   input logic                                            reset,
   input logic                                            req_tvalid,
   input logic                                            req_tready,
   input logic [((SAMPLE_WIDTH+ENV_FRAC_BITS+8)/8)*8-1:0] rsp_tdata,
   input logic [lae_pkg::SEGMENT_WIDTH-1:0]               rsp_tuser,
   input logic                                            rsp_tvalid,
   input logic                                            rsp_tready
);
   import lae_pkg::*;

   localparam int QW = ENV_FRAC_BITS + 1;
   localparam logic [QW-1:0] ENV_ONE = QW'(1) << ENV_FRAC_BITS;

   logic [QW-1:0] env;
   logic [SAMPLE_WIDTH-1:0] smp;

   assign env = rsp_tdata[SAMPLE_WIDTH +: QW];
   assign smp = rsp_tdata[SAMPLE_WIDTH-1:0];

   // stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one word in processing at a time, so no accept right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while busy");

   a_past_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == SEG_PAST_END |-> env == '0 && smp == '0)
      else $error("nonzero output past end");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> env <= ENV_ONE && rsp_tuser <= SEG_PAST_END)
      else $error("envelope or segment out of range");

   a_sustain_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == SEG_ATTACK |-> env < ENV_ONE)
      else $error("attack reached full scale");

endmodule

bind linear_adsr_envelope_top lae_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH),
   .ENV_FRAC_BITS(ENV_FRAC_BITS)
) u_lae_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);

@@ tb/sv/linear_adsr_envelope_top_tb.sv @@
// self-checking testbench for the linear adsr envelope block
module linear_adsr_envelope_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lae_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 500;
   localparam int TAIL_CYCLES = 40;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd5;
   localparam logic [27:0] LEN_MAX = 28'hFFF_FFFF;

   typedef struct packed {
      logic [15:0] sample;
      logic [2:0]  segment;
      logic [16:0] level;
   } env_word_type;

   class envelope_tracker;
      logic [27:0] attack_len;
      logic [27:0] decay_len;
      logic [16:0] sustain_level;
      logic [27:0] release_len;
      logic [27:0] total_len;
      logic [27:0] position;
      env_word_type pending_words[$];
      int          mismatches;

      function new();
         attack_len = 28'd480;
         decay_len = 28'd4800;
         sustain_level = 17'd45875;
         release_len = 28'd9600;
         total_len = 28'd48000;
         position = '0;
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void set_reg(logic [REG_INDEX_WIDTH-1:0] idx, logic [31:0] value);
         case (idx)
            REG_ATTACK_LEN: attack_len = value[27:0];
            REG_DECAY_LEN: decay_len = value[27:0];
            REG_SUSTAIN_LEVEL: sustain_level = value[16:0];
            REG_RELEASE_LEN: release_len = value[27:0];
            REG_TOTAL_LEN: total_len = value[27:0];
            default: ;
         endcase
      endfunction

      function void check_reg(logic [REG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         logic [31:0] want;
         case (idx)
            REG_ATTACK_LEN: want = 32'(attack_len);
            REG_DECAY_LEN: want = 32'(decay_len);
            REG_SUSTAIN_LEVEL: want = 32'(sustain_level);
            REG_RELEASE_LEN: want = 32'(release_len);
            default: want = 32'(total_len);
         endcase
         if (data !== want)
            flag($sformatf("register %0d read %h, expected %h", idx, data, want));
      endfunction

      function void note_sample(logic [15:0] s, logic restart);
         longint unsigned one, sus, env, p, sstart, rstart, k;
         longint sval, prod, res;
         env_word_type w;
         one = 64'd1 << 16;
         sus = (64'(sustain_level) > one) ? one : 64'(sustain_level);
         if (restart) position = '0;
         if (position >= total_len) begin
            w.segment = SEG_PAST_END;
            env = 0;
         end else begin
            p = 64'(position);
            sstart = 64'(attack_len) + 64'(decay_len);
            rstart = (total_len > release_len) ? 64'(total_len - release_len)
                                                : 64'(total_len);
            if (p < 64'(attack_len)) begin
               w.segment = SEG_ATTACK;
               env = (p * one) / 64'(attack_len);
            end else if (p < sstart) begin
               k = p - 64'(attack_len);
               w.segment = SEG_DECAY;
               env = sus + ((one - sus) * (64'(decay_len) - k)) / 64'(decay_len);
            end else if (p < rstart) begin
               w.segment = SEG_SUSTAIN;
               env = sus;
            end else begin
               k = p - rstart;
               w.segment = SEG_RELEASE;
               env = (sus * (64'(release_len) - k)) / 64'(release_len);
            end
            position = position + 28'd1;
         end
         sval = longint'($signed(s));
         prod = sval * longint'(env);
         res = prod >>> 16;
         w.sample = res[15:0];
         w.level = env[16:0];
         pending_words.push_back(w);
      endfunction

      function void check_word(logic [15:0] s, logic [2:0] seg, logic [16:0] lvl);
         env_word_type w;
         if (pending_words.size() == 0) begin
            flag($sformatf("unexpected word sample %h segment %0d envelope %0d",
                           s, seg, lvl));
            return;
         end
         w = pending_words.pop_front();
         if (s !== w.sample)
            flag($sformatf("sample_out %h, expected %h", s, w.sample));
         if (seg !== w.segment)
            flag($sformatf("segment %0d, expected %0d", seg, w.segment));
         if (lvl !== w.level)
            flag($sformatf("envelope %0d, expected %0d", lvl, w.level));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic [SEGMENT_WIDTH-1:0] rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   envelope_tracker tracker = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int cycles = 0;

   linear_adsr_envelope_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_word(rsp_tdata[15:0], rsp_tuser, rsp_tdata[32:16]);
   end

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin
      int held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            held = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (held > 0) begin
            held--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 18);
         end
      end
   end

   task automatic send_sample(input logic [15:0] s, input logic restart);
      int gap;
      gap = (!quiet && $urandom_range(99) < 18) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= s;
      req_tuser <= restart;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_sample(s, restart);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_WIDTH-1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(idx, value);
      @(negedge clock);
      if (idx <= REG_TOTAL_LEN) begin
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         tracker.check_reg(idx, csr_prdata);
         @(negedge clock);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // junk above each register's width must be dropped
   task automatic apply_setting(input logic [27:0] atk, input logic [27:0] dec,
                                input logic [16:0] sus, input logic [27:0] rel,
                                input logic [27:0] tot);
      write_reg(REG_ATTACK_LEN, {4'($urandom_range(15)), atk});
      write_reg(REG_DECAY_LEN, {4'($urandom_range(15)), dec});
      write_reg(REG_SUSTAIN_LEVEL, {15'($urandom()), sus});
      write_reg(REG_RELEASE_LEN, {4'($urandom_range(15)), rel});
      write_reg(REG_TOTAL_LEN, {4'($urandom_range(15)), tot});
   endtask

   task automatic run_stream(input int count, input int restart_pct, input bit first_restart);
      logic r;
      for (int i = 0; i < count; i++) begin
         r = (i == 0 && first_restart) || ($urandom_range(99) < restart_pct);
         send_sample(16'($urandom()), r);
      end
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   initial begin
      logic [15:0] corner[8];
      logic [16:0] sus;
      corner = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                 16'h0000, 16'h4000, 16'hC000, 16'h8001};
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tvalid = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, then a short envelope that passes every segment
      for (int i = 0; i < 3; i++) send_sample(corner[i], 1'b0);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      apply_setting(28'd4, 28'd3, 17'h1FFFF, 28'd5, 28'd20);
      for (int i = 0; i < 22; i++) send_sample(corner[i % 8], i == 0);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);

      // write to an unmapped address, then shrink the length under the position
      write_reg(REG_UNMAPPED, $urandom());
      apply_setting(28'd3, 28'd3, 17'd30000, 28'd50, 28'd200);
      run_stream(40, 0, 1'b1);
      write_reg(REG_TOTAL_LEN, 32'd10);
      run_stream(8, 0, 1'b0);
      run_stream(15, 0, 1'b1);

      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(3))
            0: sus = 17'd0;
            1: sus = 17'd65536;
            2: sus = 17'h1FFFF;
            default: sus = 17'($urandom());
         endcase
         if (ph == 0)
            apply_setting(LEN_MAX, LEN_MAX, 17'd65536, LEN_MAX, LEN_MAX);
         else if (ph == 1)
            apply_setting(28'd0, 28'd0, sus, 28'd0, 28'd0);
         else if (ph == 2)
            apply_setting(28'd1, 28'd1, 17'd0, LEN_MAX, 28'd30);
         else
            apply_setting(28'($urandom_range(12)), 28'($urandom_range(12)), sus,
                          28'($urandom_range(20)), 28'($urandom_range(50)));
         quiet = (ph == 5);
         if (ph == 4) hold_request = 1'b1;
         run_stream(125, $urandom_range(2, 8), ph[0]);
      end
      quiet = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
